// ===== hdl/mbcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbcf_pkg
// Shared types, constants and table builders for the master bus compressor
// and filter.
// ----------------------------------------------------------------------------
package mbcf_pkg;

  // build-time defaults
  localparam int FILTER_KIND_DEF    = 1;
  localparam int LOG_TABLE_BITS_DEF = 8;

  // serial multiplier operand widths
  localparam int MUL_AW = 48;
  localparam int MUL_BW = 25;
  localparam int MUL_LW = 5;

  // register indexes
  localparam logic [2:0] REG_MASTER_GAIN     = 3'd0;
  localparam logic [2:0] REG_ATTACK_COEFF    = 3'd1;
  localparam logic [2:0] REG_RELEASE_COEFF   = 3'd2;
  localparam logic [2:0] REG_THRESHOLD_LEVEL = 3'd3;
  localparam logic [2:0] REG_RATIO_INVERSE   = 3'd4;
  localparam logic [2:0] REG_COEFF_FORWARD   = 3'd5;
  localparam logic [2:0] REG_COEFF_FB1       = 3'd6;
  localparam logic [2:0] REG_COEFF_FB2       = 3'd7;

  localparam int CFG_W = 19;
  localparam int UNITY = 65536;

  // register reset values
  localparam logic [15:0] MASTER_GAIN_RST = 16'd4096;
  localparam logic [16:0] COEFF_ONE_RST   = 17'd65536;
  localparam logic [18:0] THRESHOLD_RST   = 19'd32768;
  localparam logic [17:0] FORWARD_RST     = 18'd65536;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_GAIN, ST_GAIN_W, ST_ENV, ST_ENV_W, ST_CMP,
    ST_NORM, ST_LG0, ST_LG1, ST_LG_W, ST_SLOPE, ST_SLOPE_W,
    ST_EX0, ST_EX1, ST_EX_W, ST_REL, ST_REL_W, ST_VOL, ST_VOL_W,
    ST_F0, ST_F0_W, ST_F1, ST_F1_W, ST_F2, ST_F2_W, ST_OUT
  } seq_state_t;

  // request to the serial multiplier
  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
    logic [MUL_LW-1:0] len;
  } mul_req_t;

  // integer square root, shift and subtract
  function automatic logic [63:0] isqrt64(logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > n) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2(1 + i/2^ltb) in Q0.16 by repeated squaring
  function automatic logic [16:0] lg_entry(int i, int ltb);
    logic [63:0] x;
    logic [63:0] res;
    x = (64'd1 << 30) + (64'(i) << (30 - ltb));
    res = 64'd0;
    if (i >= (1 << ltb)) return 17'(UNITY);
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      res = res << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        res = res | 64'd1;
      end
    end
    return res[16:0];
  endfunction

  // 2^(-i/2^ltb) in Q0.16, rounded
  function automatic logic [16:0] ex_entry(int i, int ltb);
    logic [63:0] root [0:16];
    logic [63:0] f;
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rm;
    root[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) root[k] = isqrt64(root[k-1] << 30);
    f = 64'(i) << (16 - ltb);
    p = 64'd1 << 30;
    for (int k = 0; k <= 16; k++) begin
      if (((f >> (16 - k)) & 64'd1) != 64'd0)
        p = (p * root[k] + (64'd1 << 29)) >> 30;
    end
    // long division of (2^46 + p/2) by p
    num = (64'd1 << 46) + (p >> 1);
    q = 64'd0;
    rm = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      rm = (rm << 1) | ((num >> k) & 64'd1);
      if (rm >= p) begin
        rm = rm - p;
        q = q | (64'd1 << k);
      end
    end
    return q[16:0];
  endfunction

endpackage

// ===== hdl/mbcf_sermul.sv =====
// ----------------------------------------------------------------------------
// mbcf_sermul
// Bit-serial signed multiplier: one multiplier bit per cycle, the top bit of
// the given length carries negative weight.
// ----------------------------------------------------------------------------
module mbcf_sermul (
  input  logic               clk,
  input  logic               rst,
  input  mbcf_pkg::mul_req_t req,
  output logic               done,
  output logic [mbcf_pkg::MUL_AW-1:0] prod
);

  localparam logic [mbcf_pkg::MUL_LW-1:0] CNT_LAST = 1;

  logic                        busy;
  logic [mbcf_pkg::MUL_LW-1:0] cnt;
  logic signed [mbcf_pkg::MUL_AW-1:0] acc;
  logic signed [mbcf_pkg::MUL_AW-1:0] mc;
  logic signed [mbcf_pkg::MUL_BW-1:0] mp;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= req.len;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_LAST);
      done <= (cnt == CNT_LAST);
    end else begin
      done <= 1'b0;
    end
  end

  // shift and add datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      mc  <= $signed(req.a);
      mp  <= $signed(req.b);
    end else if (busy) begin
      if (mp[0]) begin
        if (cnt == CNT_LAST) acc <= acc - mc;
        else acc <= acc + mc;
      end
      mc <= mc <<< 1;
      mp <= mp >>> 1;
    end
  end

  assign prod = acc;

endmodule

// ===== hdl/master_bus_compressor_filter.sv =====
// ----------------------------------------------------------------------------
// master_bus_compressor_filter
// Master gain, feed-forward compressor and low-pass filter for one audio bus.
// ----------------------------------------------------------------------------
// Samples enter on the sample channel (mixed_sample, block_start) under
// sample_valid/sample_stall; one result leaves per sample on the result
// channel (out_sample, clipped) under result_valid/result_stall.
// Each sample is worked through one shared bit-serial multiplier, one
// multiplier bit per cycle, driven by a sequencer. When compressing, the
// sequencer adds the two log2 steps, the slope and the exp2 step, and
// one step per normalizing shift of envelope and threshold; the exp2
// multiply is skipped when the gain drops to zero.
// One sample is processed at a time; sample_stall is high while busy.
// The result register lets the next sample be taken while a result waits;
// when the receiver stalls, the sequencer holds at its last step until the
// result register frees, and the result stays stable meanwhile.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, which the block does not enforce.
// Reset (rst, synchronous) loads default registers, clears envelope and
// filter history and sets the gain to unity.
// block_start clears the envelope and sets the gain back to unity ahead
// of that sample only.
// ----------------------------------------------------------------------------
module master_bus_compressor_filter #(
  parameter int FILTER_KIND    = mbcf_pkg::FILTER_KIND_DEF,
  parameter int LOG_TABLE_BITS = mbcf_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [19:0]         mixed_sample,
  input  logic                       block_start,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [15:0]         out_sample,
  output logic                       clipped,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [mbcf_pkg::CFG_W-1:0] cfg_data
);

  localparam int LTB   = LOG_TABLE_BITS;
  localparam int TBL_N = 1 << LTB;
  localparam int LREM  = 23 - LTB;
  localparam int EREM  = 16 - LTB;

  typedef logic [16:0] tab_t [0:TBL_N];

  function automatic tab_t build_lg();
    tab_t t;
    for (int i = 0; i <= TBL_N; i++) t[i] = mbcf_pkg::lg_entry(i, LTB);
    return t;
  endfunction

  function automatic tab_t build_ex();
    tab_t t;
    for (int i = 0; i <= TBL_N; i++) t[i] = mbcf_pkg::ex_entry(i, LTB);
    return t;
  endfunction

  localparam tab_t LG_TAB = build_lg();
  localparam tab_t EX_TAB = build_ex();

  function automatic logic signed [19:0] sat20(logic signed [47:0] v);
    if (v > 48'sd524287) return 20'sd524287;
    if (v < -48'sd524288) return 20'h80000;
    return v[19:0];
  endfunction

  function automatic logic signed [23:0] sat24(logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sd8388607;
    if (v < -48'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // configuration registers
  logic [15:0]        master_gain;
  logic [16:0]        attack_coeff;
  logic [16:0]        release_coeff;
  logic [18:0]        threshold_level;
  logic [16:0]        ratio_inverse;
  logic signed [17:0] coeff_forward;
  logic signed [17:0] coeff_fb1;
  logic signed [17:0] coeff_fb2;

  // working registers
  mbcf_pkg::seq_state_t state, state_next;
  logic signed [19:0] x_in;
  logic signed [19:0] s_reg;
  logic [23:0]        env;
  logic [17:0]        gain;
  logic signed [19:0] v_reg;
  logic signed [19:0] d0, d1;
  logic signed [23:0] o0, o1;
  logic signed [47:0] facc;
  logic [21:0]        le, lt;
  logic [23:0]        nv;
  logic [4:0]         pos;
  logic               which;
  logic [16:0]        t0;
  logic [22:0]        ereg;

  mbcf_pkg::mul_req_t mreq;
  logic               mdone;
  logic [47:0]        mprod;
  logic signed [47:0] prod;

  mbcf_sermul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .prod (mprod)
  );

  assign prod = $signed(mprod);

  // derived values
  logic [16:0]        att, rel, rinv;
  logic [18:0]        thr_eff;
  logic [20:0]        mag;
  logic signed [24:0] ediff;
  logic signed [18:0] rdiff;
  logic signed [18:0] fb0_alt;
  logic signed [22:0] fsum;
  logic [21:0]        lval;
  logic [LTB-1:0]     lidx;
  logic [LTB:0]       lidx1;
  logic [LREM-1:0]    lrem;
  logic [LTB-1:0]     eidx;
  logic [LTB:0]       eidx1;
  logic [EREM-1:0]    erem;
  logic [6:0]         en;
  logic [21:0]        logv;
  logic [16:0]        eval;
  logic signed [47:0] rnd16;
  logic signed [47:0] env_upd;
  logic signed [47:0] g_upd;
  logic signed [23:0] y;
  logic               compress;
  logic               slot_free;
  logic               accept;

  assign att  = (attack_coeff  > 17'd65536) ? 17'd65536 : attack_coeff;
  assign rel  = (release_coeff > 17'd65536) ? 17'd65536 : release_coeff;
  assign rinv = (ratio_inverse > 17'd65536) ? 17'd65536 : ratio_inverse;
  assign thr_eff = (threshold_level == 19'd0) ? 19'd1 : threshold_level;

  assign mag   = s_reg[19] ? (21'd0 - 21'($signed(s_reg))) : {1'b0, s_reg};
  assign ediff = $signed({4'b0, mag}) - $signed({1'b0, env});
  assign rdiff = 19'sd65536 - $signed({1'b0, gain});
  assign fb0_alt = 19'sd65536 - 19'(coeff_forward);
  assign fsum  = 23'(v_reg) + (23'(d0) <<< 1) + 23'(d1);
  assign lval  = (le > lt) ? (le - lt) : 22'd0;
  assign compress = env > {5'b0, thr_eff};

  assign lidx  = nv[22 -: LTB];
  assign lidx1 = {1'b0, lidx} + 1'b1;
  assign lrem  = nv[LREM-1:0];
  assign eidx  = ereg[15 -: LTB];
  assign eidx1 = {1'b0, eidx} + 1'b1;
  assign erem  = ereg[EREM-1:0];
  assign en    = ereg[22:16];

  assign rnd16   = (prod + 48'sd32768) >>> 16;
  assign env_upd = $signed({24'b0, env}) + rnd16;
  assign g_upd   = $signed({30'b0, gain}) + rnd16;
  assign logv    = {pos, 16'b0} + 22'(t0) + 22'(mprod >> LREM);
  assign eval    = t0 - 17'(mprod >> EREM);
  assign y       = sat24((facc + 48'sd32768) >>> 16);

  assign slot_free    = !result_valid || !result_stall;
  assign sample_stall = (state != mbcf_pkg::ST_IDLE);
  assign accept       = sample_valid && !sample_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain     <= mbcf_pkg::MASTER_GAIN_RST;
      attack_coeff    <= mbcf_pkg::COEFF_ONE_RST;
      release_coeff   <= mbcf_pkg::COEFF_ONE_RST;
      threshold_level <= mbcf_pkg::THRESHOLD_RST;
      ratio_inverse   <= mbcf_pkg::COEFF_ONE_RST;
      coeff_forward   <= mbcf_pkg::FORWARD_RST;
      coeff_fb1       <= '0;
      coeff_fb2       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        mbcf_pkg::REG_MASTER_GAIN:     master_gain     <= cfg_data[15:0];
        mbcf_pkg::REG_ATTACK_COEFF:    attack_coeff    <= cfg_data[16:0];
        mbcf_pkg::REG_RELEASE_COEFF:   release_coeff   <= cfg_data[16:0];
        mbcf_pkg::REG_THRESHOLD_LEVEL: threshold_level <= cfg_data[18:0];
        mbcf_pkg::REG_RATIO_INVERSE:   ratio_inverse   <= cfg_data[16:0];
        mbcf_pkg::REG_COEFF_FORWARD:   coeff_forward   <= cfg_data[17:0];
        mbcf_pkg::REG_COEFF_FB1:       coeff_fb1       <= cfg_data[17:0];
        mbcf_pkg::REG_COEFF_FB2:       coeff_fb2       <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mbcf_pkg::ST_IDLE:    if (accept) state_next = mbcf_pkg::ST_GAIN;
      mbcf_pkg::ST_GAIN:    state_next = mbcf_pkg::ST_GAIN_W;
      mbcf_pkg::ST_GAIN_W:  if (mdone) state_next = mbcf_pkg::ST_ENV;
      mbcf_pkg::ST_ENV:     state_next = mbcf_pkg::ST_ENV_W;
      mbcf_pkg::ST_ENV_W:   if (mdone) state_next = mbcf_pkg::ST_CMP;
      mbcf_pkg::ST_CMP:     state_next = compress ? mbcf_pkg::ST_NORM : mbcf_pkg::ST_REL;
      mbcf_pkg::ST_NORM:    if (nv[23]) state_next = mbcf_pkg::ST_LG0;
      mbcf_pkg::ST_LG0:     state_next = mbcf_pkg::ST_LG1;
      mbcf_pkg::ST_LG1:     state_next = mbcf_pkg::ST_LG_W;
      mbcf_pkg::ST_LG_W:
        if (mdone) state_next = which ? mbcf_pkg::ST_SLOPE : mbcf_pkg::ST_NORM;
      mbcf_pkg::ST_SLOPE:   state_next = mbcf_pkg::ST_SLOPE_W;
      mbcf_pkg::ST_SLOPE_W: if (mdone) state_next = mbcf_pkg::ST_EX0;
      mbcf_pkg::ST_EX0:
        state_next = (en >= 7'd17) ? mbcf_pkg::ST_VOL : mbcf_pkg::ST_EX1;
      mbcf_pkg::ST_EX1:     state_next = mbcf_pkg::ST_EX_W;
      mbcf_pkg::ST_EX_W:    if (mdone) state_next = mbcf_pkg::ST_VOL;
      mbcf_pkg::ST_REL:     state_next = mbcf_pkg::ST_REL_W;
      mbcf_pkg::ST_REL_W:   if (mdone) state_next = mbcf_pkg::ST_VOL;
      mbcf_pkg::ST_VOL:     state_next = mbcf_pkg::ST_VOL_W;
      mbcf_pkg::ST_VOL_W:   if (mdone) state_next = mbcf_pkg::ST_F0;
      mbcf_pkg::ST_F0:      state_next = mbcf_pkg::ST_F0_W;
      mbcf_pkg::ST_F0_W:    if (mdone) state_next = mbcf_pkg::ST_F1;
      mbcf_pkg::ST_F1:      state_next = mbcf_pkg::ST_F1_W;
      mbcf_pkg::ST_F1_W:
        if (mdone) state_next = (FILTER_KIND != 0) ? mbcf_pkg::ST_F2 : mbcf_pkg::ST_OUT;
      mbcf_pkg::ST_F2:      state_next = mbcf_pkg::ST_F2_W;
      mbcf_pkg::ST_F2_W:    if (mdone) state_next = mbcf_pkg::ST_OUT;
      mbcf_pkg::ST_OUT:     if (slot_free) state_next = mbcf_pkg::ST_IDLE;
      default:              state_next = mbcf_pkg::ST_IDLE;
    endcase
  end

  // multiplier requests
  always_comb begin
    mreq = '0;
    case (state)
      mbcf_pkg::ST_GAIN: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(x_in);
        mreq.b     = {9'b0, master_gain};
        mreq.len   = 5'd17;
      end
      mbcf_pkg::ST_ENV: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(ediff);
        mreq.b     = {8'b0, att};
        mreq.len   = 5'd18;
      end
      mbcf_pkg::ST_LG1: begin
        mreq.start = 1'b1;
        mreq.a     = {31'b0, LG_TAB[lidx1] - t0};
        mreq.b     = 25'(lrem);
        mreq.len   = 5'(LREM + 1);
      end
      mbcf_pkg::ST_SLOPE: begin
        mreq.start = 1'b1;
        mreq.a     = {26'b0, lval};
        mreq.b     = {8'b0, 17'd65536 - rinv};
        mreq.len   = 5'd18;
      end
      mbcf_pkg::ST_EX1: begin
        mreq.start = 1'b1;
        mreq.a     = {31'b0, t0 - EX_TAB[eidx1]};
        mreq.b     = 25'(erem);
        mreq.len   = 5'(EREM + 1);
      end
      mbcf_pkg::ST_REL: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(rdiff);
        mreq.b     = {8'b0, rel};
        mreq.len   = 5'd18;
      end
      mbcf_pkg::ST_VOL: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(s_reg);
        mreq.b     = {7'b0, gain};
        mreq.len   = 5'd19;
      end
      mbcf_pkg::ST_F0: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(coeff_forward);
        if (FILTER_KIND != 0) begin
          mreq.b   = 25'(fsum);
          mreq.len = 5'd23;
        end else begin
          mreq.b   = 25'(v_reg);
          mreq.len = 5'd20;
        end
      end
      mbcf_pkg::ST_F1: begin
        mreq.start = 1'b1;
        mreq.a     = (FILTER_KIND != 0) ? 48'(coeff_fb1) : 48'(fb0_alt);
        mreq.b     = 25'(o0);
        mreq.len   = 5'd24;
      end
      mbcf_pkg::ST_F2: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(coeff_fb2);
        mreq.b     = 25'(o1);
        mreq.len   = 5'd24;
      end
      default: mreq = '0;
    endcase
  end

  // state register and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbcf_pkg::ST_IDLE;
      env   <= '0;
      gain  <= 18'd65536;
      d0    <= '0;
      d1    <= '0;
      o0    <= '0;
      o1    <= '0;
    end else begin
      state <= state_next;
      if (accept && block_start) begin
        env  <= '0;
        gain <= 18'd65536;
      end
      if (state == mbcf_pkg::ST_ENV_W && mdone) env <= env_upd[23:0];
      if (state == mbcf_pkg::ST_REL_W && mdone) gain <= g_upd[17:0];
      if (state == mbcf_pkg::ST_EX0 && en >= 7'd17) gain <= '0;
      if (state == mbcf_pkg::ST_EX_W && mdone) gain <= {1'b0, eval} >> en[4:0];
      if (state == mbcf_pkg::ST_OUT && slot_free) begin
        o0 <= y;
        if (FILTER_KIND != 0) begin
          d1 <= d0;
          d0 <= v_reg;
          o1 <= o0;
        end
      end
    end
  end

  // per-sample working registers
  always_ff @(posedge clk) begin
    if (accept) x_in <= mixed_sample;
    case (state)
      mbcf_pkg::ST_GAIN_W:
        if (mdone) s_reg <= sat20((prod + 48'sd2048) >>> 12);
      mbcf_pkg::ST_CMP: begin
        nv    <= env;
        pos   <= 5'd23;
        which <= 1'b0;
      end
      mbcf_pkg::ST_NORM:
        if (!nv[23]) begin
          nv  <= nv << 1;
          pos <= pos - 1'b1;
        end
      mbcf_pkg::ST_LG0: t0 <= LG_TAB[{1'b0, lidx}];
      mbcf_pkg::ST_LG_W:
        if (mdone) begin
          if (!which) begin
            le    <= logv;
            nv    <= {5'b0, thr_eff};
            pos   <= 5'd23;
            which <= 1'b1;
          end else begin
            lt <= logv;
          end
        end
      mbcf_pkg::ST_SLOPE_W: if (mdone) ereg <= mprod[38:16];
      mbcf_pkg::ST_EX0: t0 <= EX_TAB[{1'b0, eidx}];
      mbcf_pkg::ST_VOL_W: if (mdone) v_reg <= sat20(rnd16);
      mbcf_pkg::ST_F0_W: if (mdone) facc <= prod;
      mbcf_pkg::ST_F1_W:
        if (mdone) facc <= (FILTER_KIND != 0) ? (facc - prod) : (facc + prod);
      mbcf_pkg::ST_F2_W: if (mdone) facc <= facc - prod;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == mbcf_pkg::ST_OUT && slot_free) ||
                      (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mbcf_pkg::ST_OUT && slot_free) begin
      clipped <= (y > 24'sd32767) || (y < -24'sd32768);
      if (y > 24'sd32767) out_sample <= 16'sd32767;
      else if (y < -24'sd32768) out_sample <= 16'h8000;
      else out_sample <= y[15:0];
    end
  end

endmodule

// ===== tb/tb_master_bus_compressor_filter.sv =====
// ----------------------------------------------------------------------------
// tb_master_bus_compressor_filter
// Self-checking bench for the master bus compressor and low-pass filter.
// Samples are pushed through the sample channel in random bursts while the
// result channel stalls on its own pattern. A fixed-point predictor of the
// gain, envelope, compressor and filter computes each expected result,
// which is compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_master_bus_compressor_filter;

  localparam int TBITS      = mbcf_pkg::LOG_TABLE_BITS_DEF;
  localparam int TSIZE      = 1 << TBITS;
  localparam int IDLE_LIMIT = 20000;
  localparam longint Q16_ONE = 65536;

  typedef struct {
    logic signed [15:0] smp;
    logic               clip;
  } result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic signed [19:0]      mixed_sample = '0;
  logic                    block_start = 1'b0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [15:0]      out_sample;
  logic                    clipped;
  logic                    cfg_write = 1'b0;
  logic [2:0]              cfg_index = '0;
  logic [mbcf_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state and register copy
  logic [18:0]             regs [0:7];
  longint                  env_level;
  longint                  gain_level;
  longint                  in_hist [0:1];
  longint                  out_hist [0:1];
  longint unsigned         log_tab [0:TSIZE];
  longint unsigned         exp_tab [0:TSIZE];

  result_t                 expected_results [$];
  int                      errors = 0;
  int                      samples_sent = 0;
  int                      results_seen = 0;
  int                      clip_count = 0;
  int                      burst_left = 0;
  int                      idle_cycles = 0;
  int                      stall_mode = 0;
  int                      stall_left = 0;

  master_bus_compressor_filter i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .mixed_sample (mixed_sample),
    .block_start  (block_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_sample   (out_sample),
    .clipped      (clipped),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic build_tables();
    longint unsigned roots [0:16];
    longint unsigned x;
    longint unsigned acc;
    longint unsigned frac;
    longint unsigned prod;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    // log2 by repeated squaring of the mantissa
    for (int i = 0; i < TSIZE; i++) begin
      x = (64'd1 << 30) + (longint'(i) << (30 - TBITS));
      acc = 0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        acc = acc << 1;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          acc = acc | 1;
        end
      end
      log_tab[i] = acc;
    end
    log_tab[TSIZE] = Q16_ONE;
    // 2^-f from products of successive square roots of two
    for (int i = 0; i <= TSIZE; i++) begin
      frac = longint'(i) << (16 - TBITS);
      prod = 64'd1 << 30;
      for (int k = 0; k <= 16; k++)
        if (((frac >> (16 - k)) & 1) != 0) prod = (prod * roots[k] + (64'd1 << 29)) >> 30;
      exp_tab[i] = ((64'd1 << 46) + prod / 2) / prod;
    end
  endtask

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint unsigned log2_q16(longint unsigned v);
    int unsigned msb;
    longint unsigned frac;
    longint unsigned idx;
    longint unsigned rem;
    msb = 0;
    v = v & 64'hFFFFFF;
    if (v == 0) v = 1;
    while (msb < 24 && (v >> (msb + 1)) != 0) msb++;
    frac = (v << (30 - msb)) - (64'd1 << 30);
    idx = frac >> (30 - TBITS);
    rem = frac & ((64'd1 << (30 - TBITS)) - 1);
    return (longint'(msb) << 16) + log_tab[idx]
           + (((log_tab[idx+1] - log_tab[idx]) * rem) >> (30 - TBITS));
  endfunction

  function automatic longint unsigned exp2_neg(longint unsigned e);
    longint unsigned whole;
    longint unsigned idx;
    longint unsigned rem;
    longint unsigned val;
    whole = e >> 16;
    if (whole >= 17) return 0;
    idx = (e & 16'hFFFF) >> (16 - TBITS);
    rem = e & ((64'd1 << (16 - TBITS)) - 1);
    val = exp_tab[idx] - (((exp_tab[idx] - exp_tab[idx+1]) * rem) >> (16 - TBITS));
    return val >> whole;
  endfunction

  task automatic reset_predictor();
    regs[mbcf_pkg::REG_MASTER_GAIN]     = 19'(mbcf_pkg::MASTER_GAIN_RST);
    regs[mbcf_pkg::REG_ATTACK_COEFF]    = 19'(mbcf_pkg::COEFF_ONE_RST);
    regs[mbcf_pkg::REG_RELEASE_COEFF]   = 19'(mbcf_pkg::COEFF_ONE_RST);
    regs[mbcf_pkg::REG_THRESHOLD_LEVEL] = 19'(mbcf_pkg::THRESHOLD_RST);
    regs[mbcf_pkg::REG_RATIO_INVERSE]   = 19'(mbcf_pkg::COEFF_ONE_RST);
    regs[mbcf_pkg::REG_COEFF_FORWARD]   = 19'(mbcf_pkg::FORWARD_RST);
    regs[mbcf_pkg::REG_COEFF_FB1]       = '0;
    regs[mbcf_pkg::REG_COEFF_FB2]       = '0;
    env_level = 0;
    gain_level = Q16_ONE;
    in_hist[0] = 0;
    in_hist[1] = 0;
    out_hist[0] = 0;
    out_hist[1] = 0;
  endtask

  // one sample through gain, compressor, filter and clamp
  function automatic result_t compress_and_filter(logic signed [19:0] smp, logic first);
    result_t r;
    longint x, s, mag, att, rel, thr, v, y, a0, acc;
    longint unsigned le, lt, l, rinv;
    x = longint'(smp);
    if (first) begin
      env_level = 0;
      gain_level = Q16_ONE;
    end
    s = clamp(round_shift(x * longint'(regs[mbcf_pkg::REG_MASTER_GAIN][15:0]), 12),
              -524288, 524287);
    mag = (s < 0) ? -s : s;
    att = clamp(longint'(regs[mbcf_pkg::REG_ATTACK_COEFF][16:0]), 0, Q16_ONE);
    env_level += round_shift((mag - env_level) * att, 16);
    thr = (regs[mbcf_pkg::REG_THRESHOLD_LEVEL] == 0) ? 1
          : longint'(regs[mbcf_pkg::REG_THRESHOLD_LEVEL]);
    if (env_level > thr) begin
      le = log2_q16(env_level);
      lt = log2_q16(thr);
      l = (le > lt) ? le - lt : 0;
      rinv = clamp(longint'(regs[mbcf_pkg::REG_RATIO_INVERSE][16:0]), 0, Q16_ONE);
      gain_level = longint'(exp2_neg((l * (Q16_ONE - rinv)) >> 16));
    end else begin
      rel = clamp(longint'(regs[mbcf_pkg::REG_RELEASE_COEFF][16:0]), 0, Q16_ONE);
      gain_level += round_shift((Q16_ONE - gain_level) * rel, 16);
    end
    v = clamp(round_shift(s * gain_level, 16), -524288, 524287);
    a0 = longint'($signed(regs[mbcf_pkg::REG_COEFF_FORWARD][17:0]));
    if (mbcf_pkg::FILTER_KIND_DEF != 0) begin
      acc = a0 * (v + 2 * in_hist[0] + in_hist[1])
          - longint'($signed(regs[mbcf_pkg::REG_COEFF_FB1][17:0])) * out_hist[0]
          - longint'($signed(regs[mbcf_pkg::REG_COEFF_FB2][17:0])) * out_hist[1];
      y = clamp(round_shift(acc, 16), -8388608, 8388607);
      in_hist[1] = in_hist[0];
      in_hist[0] = v;
      out_hist[1] = out_hist[0];
      out_hist[0] = y;
    end else begin
      acc = a0 * v + (Q16_ONE - a0) * out_hist[0];
      y = clamp(round_shift(acc, 16), -8388608, 8388607);
      out_hist[0] = y;
    end
    r.clip = (y > 32767 || y < -32768);
    r.smp = 16'(clamp(y, -32768, 32767));
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // send one sample beat, then maybe leave a gap before the next burst
  task automatic send_sample(logic signed [19:0] smp, logic first);
    int gap;
    @(negedge clk);
    sample_valid <= 1'b1;
    mixed_sample <= smp;
    block_start  <= first;
    do @(posedge clk); while (sample_stall);
    expected_results.push_back(compress_and_filter(smp, first));
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // let every pending result drain before touching registers
  task automatic drain();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [18:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    regs[idx] = val;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_all(logic [18:0] mg, logic [18:0] att, logic [18:0] rel,
                         logic [18:0] thr, logic [18:0] rinv, logic [18:0] a0,
                         logic [18:0] b1, logic [18:0] b2);
    drain();
    set_reg(mbcf_pkg::REG_MASTER_GAIN, mg & 19'hFFFF);
    set_reg(mbcf_pkg::REG_ATTACK_COEFF, att & 19'h1FFFF);
    set_reg(mbcf_pkg::REG_RELEASE_COEFF, rel & 19'h1FFFF);
    set_reg(mbcf_pkg::REG_THRESHOLD_LEVEL, thr);
    set_reg(mbcf_pkg::REG_RATIO_INVERSE, rinv & 19'h1FFFF);
    set_reg(mbcf_pkg::REG_COEFF_FORWARD, a0 & 19'h3FFFF);
    set_reg(mbcf_pkg::REG_COEFF_FB1, b1 & 19'h3FFFF);
    set_reg(mbcf_pkg::REG_COEFF_FB2, b2 & 19'h3FFFF);
    end_writes();
  endtask

  // ---------------------------------------------------------------- tests

  // full-scale, zero and alternating-bit samples under the reset settings
  task automatic test_sample_extremes();
    send_sample(20'sh80000, 1'b1);
    send_sample(20'sh7FFFF, 1'b0);
    send_sample(20'sh00000, 1'b0);
    send_sample(-20'sd1, 1'b0);
    send_sample(20'sh55555, 1'b1);
    send_sample(20'shAAAAA, 1'b0);
  endtask

  // filtered value of exactly +1.0 must report a clip
  task automatic test_clamp_edge();
    send_sample(20'sd0, 1'b1);
    send_sample(20'sd0, 1'b0);
    send_sample(20'sd32768, 1'b0);
    send_sample(20'sd0, 1'b0);
    send_sample(20'sd0, 1'b0);
    send_sample(-20'sd32768, 1'b0);
  endtask

  // compression, heavy attenuation, saturating coefficients, zero threshold
  task automatic test_compression();
    set_all(19'd65535, 19'h1FFFF, 19'h1FFFF, 19'd0, 19'd0, 19'd65536, 19'd0, 19'd0);
    send_sample(20'sh7FFFF, 1'b1);
    send_sample(20'sd1000, 1'b0);
    send_sample(-20'sd300000, 1'b0);
    set_all(19'd4096, 19'd8000, 19'd2000, 19'd16384, 19'd16384, 19'd65536, 19'd0, 19'd0);
    send_sample(20'sd200000, 1'b1);
    send_sample(20'sd200000, 1'b0);
    send_sample(20'sd10, 1'b0);
    send_sample(20'sd10, 1'b1);
    set_all(19'd0, 19'd0, 19'd0, 19'h7FFFF, 19'd65536, 19'h20000, 19'h1FFFF, 19'h20000);
    send_sample(20'sh7FFFF, 1'b1);
    send_sample(20'sh80000, 1'b0);
  endtask

  // random settings with well-formed block sequences and some noise
  task automatic test_random_settings();
    int block_left;
    logic first;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(19'd4096, 19'd3000, 19'd500, 19'd20000, 19'd16384,
                   19'd1200, 19'h3FFFF & -19'sd100000, 19'd40000);
        1: set_all(19'd65535, 19'd65536, 19'd65536, 19'd1, 19'd0,
                   19'd65536, 19'd0, 19'd0);
        2: set_all(19'd0, 19'd0, 19'd0, 19'h7FFFF, 19'd65536,
                   19'h1FFFF, 19'h1FFFF, 19'h1FFFF);
        default: set_all(19'($urandom_range(0, 65535)), 19'($urandom_range(0, 131071)),
                         19'($urandom_range(0, 131071)), 19'($urandom_range(0, 524287)),
                         19'($urandom_range(0, 131071)), 19'($urandom_range(0, 262143)),
                         ($urandom_range(0, 1) != 0) ? 19'($urandom_range(0, 262143))
                                                     : 19'h3FFFF & -19'sd90000,
                         19'($urandom_range(0, 65535)));
      endcase
      block_left = 0;
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          first = 1'($urandom_range(0, 1));
        end else begin
          first = (block_left == 0);
          if (first) block_left = $urandom_range(1, 40);
          block_left--;
        end
        send_sample(20'($urandom), first);
      end
    end
  endtask

  // ---------------------------------------------------------------- monitors

  // result stall pattern: quiet, light and heavy stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 3) == 0);
      default: result_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: out_sample=%0d clipped=%0b", out_sample, clipped);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.clip) clip_count++;
        if (out_sample !== exp_r.smp) begin
          $error("out_sample mismatch: expected %0d actual %0d", exp_r.smp, out_sample);
          errors++;
        end
        if (clipped !== exp_r.clip) begin
          $error("clipped mismatch: expected %0b actual %0b", exp_r.clip, clipped);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL master_bus_compressor_filter");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    reset_predictor();
    build_tables();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_sample_extremes();
    test_clamp_edge();
    test_compression();
    test_random_settings();
    drain();
    repeat (300) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("covered %0d samples, %0d results checked, %0d clipped",
             samples_sent, results_seen, clip_count);
    if (errors == 0) begin
      $display("PASS master_bus_compressor_filter");
    end else begin
      $display("FAIL master_bus_compressor_filter");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mbcf_pkg.sv
hdl/mbcf_sermul.sv
hdl/master_bus_compressor_filter.sv
tb/tb_master_bus_compressor_filter.sv
